@@ src/mlfd_pkg.sv @@
// Package for the meter LCD frame decoder.
// Holds frame positions, result codes, the result layout and the digit table.
// Depends on nothing.
package mlfd_pkg;

	localparam logic [3:0] POS_IDLE = 4'd0;
	localparam logic [3:0] POS_FIRST = 4'd1;
	localparam logic [3:0] POS_SECOND = 4'd2;
	localparam logic [3:0] POS_LAST = 4'd14;

	localparam logic [1:0] CUR_NONE = 2'd0;
	localparam logic [1:0] CUR_DC = 2'd1;
	localparam logic [1:0] CUR_AC = 2'd2;

	localparam logic [1:0] PT_NONE = 2'd0;
	localparam logic [1:0] PT_ONE = 2'd1;
	localparam logic [1:0] PT_TWO = 2'd2;
	localparam logic [1:0] PT_THREE = 2'd3;

	localparam logic [2:0] PRE_NONE = 3'd0;
	localparam logic [2:0] PRE_MICRO = 3'd1;
	localparam logic [2:0] PRE_NANO = 3'd2;
	localparam logic [2:0] PRE_KILO = 3'd3;
	localparam logic [2:0] PRE_MILLI = 3'd4;
	localparam logic [2:0] PRE_MEGA = 3'd5;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_DUTY = 3'd1;
	localparam logic [2:0] KIND_CAP = 3'd2;
	localparam logic [2:0] KIND_RES = 3'd3;
	localparam logic [2:0] KIND_AMPS = 3'd4;
	localparam logic [2:0] KIND_VOLTS = 3'd5;
	localparam logic [2:0] KIND_FREQ = 3'd6;
	localparam logic [2:0] KIND_TEMP = 3'd7;

	localparam int FRAME_LEN = 14;

	typedef logic [3:0] nibble_t;

	typedef struct packed {
		logic pad;
		logic [2:0] unit_kind;
		logic [2:0] scale_prefix;
		logic [5:0] status_flags;
		logic [1:0] current_kind;
		logic [1:0] point_digits;
		logic negative;
		logic [13:0] magnitude;
	} result_t;

	function automatic logic [3:0] seg_value(input logic [6:0] pattern);
		logic [3:0] digit;
		case (pattern)
			7'd5: digit = 4'd1;
			7'd91: digit = 4'd2;
			7'd31: digit = 4'd3;
			7'd39: digit = 4'd4;
			7'd62: digit = 4'd5;
			7'd126: digit = 4'd6;
			7'd21: digit = 4'd7;
			7'd127: digit = 4'd8;
			7'd63: digit = 4'd9;
			default: digit = 4'd0;
		endcase
		return digit;
	endfunction

endpackage

@@ src/meter_lcd_frame_decoder.sv @@
// Meter LCD frame decoder: frame sync on the position nibble and result decode.
// Depends on mlfd_pkg.
//
// The accepted last beat of a frame is registered in byte_s1, and its result beat in result_q.
// Throughput: one input beat per cycle; a stalled output stalls the input.
// Reset clears the frame sync and both valid flags; stored nibbles are not cleared.
module meter_lcd_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // magnitude[13:0], negative, point_digits[1:0],
	                                   // current_kind[1:0], status_flags[5:0],
	                                   // scale_prefix[2:0], unit_kind[2:0], zero pad
);
	import mlfd_pkg::*;

	logic [7:0] byte_s1;
	logic valid_s1;
	logic [3:0] expected_q;
	nibble_t nib_q [FRAME_LEN-1];
	result_t result_q;
	logic out_valid_q;

	logic advance;
	logic [3:0] pos;
	nibble_t nib;
	logic fire;
	nibble_t full [FRAME_LEN];
	logic [3:0] digit [4];
	result_t result_d;

	assign advance = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign pos = byte_s1[7:4];
	assign nib = byte_s1[3:0];
	assign fire = valid_s1 && pos != POS_FIRST && expected_q != POS_IDLE
		&& pos == expected_q && pos == POS_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= POS_IDLE;
		end else if (advance && valid_s1) begin
			if (pos == POS_FIRST) begin
				expected_q <= POS_SECOND;
			end else if (expected_q == POS_IDLE) begin
				expected_q <= POS_IDLE;
			end else if (pos != expected_q || pos == POS_LAST) begin
				expected_q <= POS_IDLE;
			end else begin
				expected_q <= pos + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			if (pos == POS_FIRST) begin
				nib_q[0] <= nib;
			end else if (expected_q != POS_IDLE && pos == expected_q && pos != POS_LAST) begin
				nib_q[pos - 4'd1] <= nib;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < FRAME_LEN - 1; i++) begin
			full[i] = nib_q[i];
		end
		full[FRAME_LEN-1] = nib;
		for (int i = 0; i < 4; i++) begin
			digit[i] = seg_value({full[1+2*i][2:0], full[2+2*i]});
		end

		result_d = '0;
		result_d.magnitude = 14'(digit[0]) * 14'd1000 + 14'(digit[1]) * 14'd100
			+ 14'(digit[2]) * 14'd10 + 14'(digit[3]);
		result_d.negative = full[1][3];

		if (full[3][3]) begin
			result_d.point_digits = PT_THREE;
		end else if (full[5][3]) begin
			result_d.point_digits = PT_TWO;
		end else if (full[7][3]) begin
			result_d.point_digits = PT_ONE;
		end else begin
			result_d.point_digits = PT_NONE;
		end

		if (full[0][3]) begin
			result_d.current_kind = CUR_AC;
		end else if (full[0][2]) begin
			result_d.current_kind = CUR_DC;
		end else begin
			result_d.current_kind = CUR_NONE;
		end

		result_d.status_flags = {full[11][0], full[11][1], full[10][0], full[9][0],
			full[0][1], full[0][0]};

		if (full[9][3]) begin
			result_d.scale_prefix = PRE_MICRO;
		end else if (full[9][2]) begin
			result_d.scale_prefix = PRE_NANO;
		end else if (full[9][1]) begin
			result_d.scale_prefix = PRE_KILO;
		end else if (full[10][3]) begin
			result_d.scale_prefix = PRE_MILLI;
		end else if (full[10][1]) begin
			result_d.scale_prefix = PRE_MEGA;
		end else begin
			result_d.scale_prefix = PRE_NONE;
		end

		if (full[10][2]) begin
			result_d.unit_kind = KIND_DUTY;
		end else if (full[11][3]) begin
			result_d.unit_kind = KIND_CAP;
		end else if (full[11][2]) begin
			result_d.unit_kind = KIND_RES;
		end else if (full[12][3]) begin
			result_d.unit_kind = KIND_AMPS;
		end else if (full[12][2]) begin
			result_d.unit_kind = KIND_VOLTS;
		end else if (full[12][1]) begin
			result_d.unit_kind = KIND_FREQ;
		end else if (full[13][2]) begin
			result_d.unit_kind = KIND_TEMP;
		end else begin
			result_d.unit_kind = KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = result_q;

endmodule

@@ sim/meter_lcd_frame_decoder_checker.sv @@
`timescale 1ns / 100ps
// Checker for the meter LCD frame decoder: tracks frame sync on input beats,
// predicts each decoded reading and compares it with the output beats.
// Depends on mlfd_pkg.
module meter_lcd_frame_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	output int          fail_count,
	output int          pending
);
	import mlfd_pkg::*;

	typedef nibble_t frame_t [FRAME_LEN];

	frame_t frame_buf;
	logic [3:0] awaited_pos;
	result_t readings_due[$];
	int n_fail = 0;

	assign fail_count = n_fail;

	function automatic int seg_to_digit(input logic [6:0] pattern);
		int digit;
		case (pattern)
			7'd5: digit = 1;
			7'd91: digit = 2;
			7'd31: digit = 3;
			7'd39: digit = 4;
			7'd62: digit = 5;
			7'd126: digit = 6;
			7'd21: digit = 7;
			7'd127: digit = 8;
			7'd63: digit = 9;
			default: digit = 0;
		endcase
		return digit;
	endfunction

	function automatic result_t decode_reading(input frame_t n);
		result_t r;
		int mag;
		r = '0;
		mag = 0;
		for (int i = 0; i < 4; i++) begin
			mag = mag * 10 + seg_to_digit({n[1 + 2 * i][2:0], n[2 + 2 * i]});
		end
		r.magnitude = mag[13:0];
		r.negative = n[1][3];

		if (n[3][3]) r.point_digits = PT_THREE;
		else if (n[5][3]) r.point_digits = PT_TWO;
		else if (n[7][3]) r.point_digits = PT_ONE;
		else r.point_digits = PT_NONE;

		if (n[0][3]) r.current_kind = CUR_AC;
		else if (n[0][2]) r.current_kind = CUR_DC;
		else r.current_kind = CUR_NONE;

		r.status_flags = {n[11][0], n[11][1], n[10][0], n[9][0], n[0][1], n[0][0]};

		if (n[9][3]) r.scale_prefix = PRE_MICRO;
		else if (n[9][2]) r.scale_prefix = PRE_NANO;
		else if (n[9][1]) r.scale_prefix = PRE_KILO;
		else if (n[10][3]) r.scale_prefix = PRE_MILLI;
		else if (n[10][1]) r.scale_prefix = PRE_MEGA;
		else r.scale_prefix = PRE_NONE;

		if (n[10][2]) r.unit_kind = KIND_DUTY;
		else if (n[11][3]) r.unit_kind = KIND_CAP;
		else if (n[11][2]) r.unit_kind = KIND_RES;
		else if (n[12][3]) r.unit_kind = KIND_AMPS;
		else if (n[12][2]) r.unit_kind = KIND_VOLTS;
		else if (n[12][1]) r.unit_kind = KIND_FREQ;
		else if (n[13][2]) r.unit_kind = KIND_TEMP;
		else r.unit_kind = KIND_NONE;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		n_fail++;
	endtask

	task automatic take_rx_byte(input logic [7:0] rx);
		logic [3:0] pos;
		pos = rx[7:4];
		if (pos == POS_FIRST) begin
			frame_buf[0] = rx[3:0];
			awaited_pos = POS_SECOND;
		end else if (awaited_pos != POS_IDLE) begin
			if (pos != awaited_pos) begin
				awaited_pos = POS_IDLE;
			end else if (pos != POS_LAST) begin
				frame_buf[pos - 4'd1] = rx[3:0];
				awaited_pos = pos + 4'd1;
			end else begin
				frame_buf[FRAME_LEN - 1] = rx[3:0];
				readings_due.push_back(decode_reading(frame_buf));
				awaited_pos = POS_IDLE;
			end
		end
	endtask

	task automatic check_reading(input logic [31:0] data);
		result_t got;
		result_t want;
		got = data;
		if (readings_due.size() == 0) begin
			report_mismatch($sformatf("result beat %h with no frame completed", data));
		end else begin
			want = readings_due.pop_front();
			if (got.magnitude != want.magnitude)
				report_mismatch($sformatf("magnitude %0d, want %0d",
					got.magnitude, want.magnitude));
			if (got.negative != want.negative)
				report_mismatch($sformatf("negative %0d, want %0d",
					got.negative, want.negative));
			if (got.point_digits != want.point_digits)
				report_mismatch($sformatf("point_digits %0d, want %0d",
					got.point_digits, want.point_digits));
			if (got.current_kind != want.current_kind)
				report_mismatch($sformatf("current_kind %0d, want %0d",
					got.current_kind, want.current_kind));
			if (got.status_flags != want.status_flags)
				report_mismatch($sformatf("status_flags %b, want %b",
					got.status_flags, want.status_flags));
			if (got.scale_prefix != want.scale_prefix)
				report_mismatch($sformatf("scale_prefix %0d, want %0d",
					got.scale_prefix, want.scale_prefix));
			if (got.unit_kind != want.unit_kind)
				report_mismatch($sformatf("unit_kind %0d, want %0d",
					got.unit_kind, want.unit_kind));
			if (got.pad != 1'b0)
				report_mismatch("pad bit set");
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_pos = POS_IDLE;
			readings_due.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				take_rx_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_reading(m_axis_tdata);
		end
		pending <= readings_due.size();
	end

endmodule

@@ sim/meter_lcd_frame_decoder_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the meter LCD frame decoder: clock, reset, byte stream
// stimulus with random idling on both sides, and the final verdict.
// Depends on mlfd_pkg, meter_lcd_frame_decoder and meter_lcd_frame_decoder_checker.
module meter_lcd_frame_decoder_tb;
	import mlfd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	int fail_count;
	int pending;
	int snd_idle = 0;
	int rcv_idle = 0;
	int bytes_sent = 0;

	localparam logic [6:0] DIGIT_PATTERNS [10] = '{7'd125, 7'd5, 7'd91, 7'd31, 7'd39,
		7'd62, 7'd126, 7'd21, 7'd127, 7'd63};
	localparam logic [6:0] PATTERN_L = 7'd104;

	localparam logic [7:0] DIRECTED_BYTES [25] = '{
		8'h25, 8'hF3, 8'h00,
		8'h1A, 8'h23, 8'h1F,
		8'h2F, 8'h3F, 8'h4F, 8'h5F, 8'h6F, 8'h7F, 8'h8F,
		8'h9F, 8'hAF, 8'hBF, 8'hCF, 8'hDF, 8'hEF,
		8'h10, 8'h20, 8'h00,
		8'h15, 8'h26, 8'hF0
	};

	meter_lcd_frame_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	meter_lcd_frame_decoder_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	task automatic send_beat(input logic [7:0] rx);
		while ($urandom_range(0, 99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rx;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_readings();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic nibble_t flag_nibble();
		nibble_t n;
		case ($urandom_range(0, 2))
			0: n = nibble_t'($urandom_range(0, 15));
			1: n = nibble_t'(4'd1 << $urandom_range(0, 3));
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [6:0] digit_pattern();
		logic [6:0] p;
		case ($urandom_range(0, 3))
			0, 1: p = DIGIT_PATTERNS[$urandom_range(0, 9)];
			2: p = $urandom_range(0, 1) ? PATTERN_L : 7'd0;
			default: p = 7'($urandom_range(0, 127));
		endcase
		return p;
	endfunction

	task automatic send_frame(input bit broken);
		nibble_t n [FRAME_LEN];
		logic [6:0] pat;
		int cut;
		int wrong_pos;
		n[0] = flag_nibble();
		for (int i = 0; i < 4; i++) begin
			pat = digit_pattern();
			n[1 + 2 * i] = {1'($urandom_range(0, 1)), pat[6:4]};
			n[2 + 2 * i] = pat[3:0];
		end
		for (int i = 9; i < FRAME_LEN; i++) begin
			n[i] = flag_nibble();
		end
		cut = broken ? $urandom_range(2, FRAME_LEN) : FRAME_LEN + 1;
		for (int p = 1; p <= FRAME_LEN; p++) begin
			if (p == cut) begin
				wrong_pos = $urandom_range(0, 15);
				if (wrong_pos == p)
					wrong_pos = p ^ 1;
				send_beat({4'(wrong_pos), 4'($urandom_range(0, 15))});
				bytes_sent++;
				return;
			end
			send_beat({4'(p), n[p - 1]});
			bytes_sent++;
		end
	endtask

	task automatic run_phase(input int sender_idle, input int receiver_idle,
			input int target);
		int pick;
		snd_idle = sender_idle;
		rcv_idle = receiver_idle;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_beat(8'($urandom_range(0, 255)));
				bytes_sent++;
			end else begin
				send_frame(pick < 20);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 25; i++) begin
			send_beat(DIRECTED_BYTES[i]);
		end
		drain_readings();

		run_phase(29, 87, 400);
		drain_readings();
		run_phase(87, 29, 800);
		drain_readings();
		run_phase(0, 0, 1200);
		drain_readings();

		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("meter_lcd_frame_decoder test passed");
		end else begin
			$display("meter_lcd_frame_decoder test failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("meter_lcd_frame_decoder test failed");
		$finish;
	end

endmodule
